/* sv/moving_average_crossover_signal_core_assert.svh */
// Assertion helpers shared by the crossover core and its divider.
// Define ASSERT_OFF to compile them away.
`ifndef MOVING_AVERAGE_CROSSOVER_SIGNAL_CORE_ASSERT_SVH
`define MOVING_AVERAGE_CROSSOVER_SIGNAL_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define MACS_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MACS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`else

`define MACS_ASSERT(lbl, ck, rn, prop, msg)
`define MACS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

/* sv/macs_pkg.sv */
`default_nettype none

package macs_pkg;

    // Window storage and price width
    localparam int WINDOW_DEPTH = 64;
    localparam int PRICE_BITS   = 32;

    localparam int PTR_W    = $clog2(WINDOW_DEPTH);
    localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int PERIOD_W = 7;
    localparam int CMP_W    = (CNT_W > PERIOD_W) ? CNT_W : PERIOD_W;
    localparam int SUM_W    = PRICE_BITS + PTR_W;
    localparam int PROD_W   = SUM_W + CMP_W;

    // Q16.16 momentum; quotient magnitude has one bit less than the word
    localparam int MOM_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int Q_W       = MOM_W - 1;
    localparam int SAT_SHIFT = Q_W - FRAC_W;
    localparam int SAT_W     = PROD_W + SAT_SHIFT;
    localparam int DIV_CNT_W = $clog2(Q_W + 1);

    localparam int THR_W  = 16;
    localparam int SIZE_W = 32;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 2;

    localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RST = PERIOD_W'(10);
    localparam logic [PERIOD_W-1:0] LONG_PERIOD_RST  = PERIOD_W'(30);
    localparam logic [THR_W-1:0]    THRESHOLD_RST    = THR_W'(1311);
    localparam logic [SIZE_W-1:0]   SIZE_RST         = SIZE_W'(65536);

    typedef enum logic [IDX_W-1:0] {
        CFG_SHORT_PERIOD = 2'd0,
        CFG_LONG_PERIOD  = 2'd1,
        CFG_THRESHOLD    = 2'd2,
        CFG_SIZE         = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_HOLD = 2'd0,
        KIND_BUY  = 2'd1,
        KIND_SELL = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_SUB,
        ST_START,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Long period: zero counts as one, above the window depth as the depth
    function automatic logic [CNT_W-1:0] clamp_long(input logic [PERIOD_W-1:0] p);
        logic [CNT_W-1:0] r;
        if (p == '0)
        begin
            r = CNT_W'(1);
        end
        else if (32'(p) > WINDOW_DEPTH)
        begin
            r = CNT_W'(WINDOW_DEPTH);
        end
        else
        begin
            r = CNT_W'(p);
        end
        return r;
    endfunction

    // Short period: zero counts as one
    function automatic logic [PERIOD_W-1:0] clamp_short(input logic [PERIOD_W-1:0] p);
        return (p == '0) ? PERIOD_W'(1) : p;
    endfunction

endpackage

`default_nettype wire

/* sv/macs_ring.sv */
`default_nettype none

module macs_ring
    import macs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [PTR_W-1:0]      waddr,
    input  wire logic [PRICE_BITS-1:0] wdata,
    input  wire logic                  re,
    input  wire logic [PTR_W-1:0]      raddr,
    output logic      [PRICE_BITS-1:0] rdata
);

    logic [PRICE_BITS-1:0] mem [WINDOW_DEPTH];
    logic [PRICE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/macs_div.sv */
`default_nettype none
`include "moving_average_crossover_signal_core_assert.svh"

module macs_div
    import macs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] dividend,
    input  wire logic [PROD_W-1:0] divisor,
    output div_stat_t              stat,
    output logic      [Q_W-1:0]    quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0]    rem_reg, rem_next;
    logic [PROD_W-1:0]    d_reg, d_next;
    logic [Q_W-1:0]       bits_reg, bits_next;
    logic [Q_W-1:0]       q_reg, q_next;

    logic [PROD_W:0] trial;
    logic            take;
    logic            sat;

    always_comb
    begin
        trial = {rem_reg, bits_reg[Q_W-1]};
        take  = trial >= {1'b0, d_reg};
        // quotient would reach 2^31: clip to all ones
        sat   = SAT_W'(dividend) >= (SAT_W'(divisor) << SAT_SHIFT);

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        bits_next = bits_reg;
        q_next    = q_reg;

        if (start)
        begin
            d_next = divisor;
            if (sat)
            begin
                q_next    = '1;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                rem_next  = PROD_W'(dividend >> SAT_SHIFT);
                bits_next = {dividend[SAT_SHIFT-1:0], FRAC_W'(0)};
                q_next    = '0;
                cnt_next  = DIV_CNT_W'(Q_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = take ? PROD_W'(trial - {1'b0, d_reg}) : PROD_W'(trial);
            bits_next = bits_reg << 1;
            q_next    = {q_reg[Q_W-2:0], take};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        d_reg    <= d_next;
        bits_reg <= bits_next;
        q_reg    <= q_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

    `MACS_ASSERT(a_rem_below_divisor, clk, rst_n, busy_reg |-> (rem_reg < d_reg), "partial remainder reached divisor")
    `MACS_ASSERT(a_no_start_when_busy, clk, rst_n, start |-> !busy_reg, "divider restarted while busy")
    `MACS_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg, "done held longer than one cycle")

endmodule

`default_nettype wire

/* sv/moving_average_crossover_signal_core.sv */
// Dual moving-average crossover core.
// Input channel: one price word per in_valid/in_ready handshake. Output channel:
// one result word per price (signal_kind, signal_size, momentum, window_full),
// held in an output register under out_valid/out_ready.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; always ready.
// Write registers only while the core is idle with no result outstanding.
// Flow: a price that leaves the window short of the long period goes from
// acceptance straight to the emit state. Otherwise the core sweeps the newest
// long-period prices out of the ring memory, one read a cycle, then multiplies,
// subtracts and runs a 31-step radix-2 divider before the emit state; the
// divider answers at once when the quotient saturates, and a zero long sum
// skips the multiply, subtract and divide. One price is in work at a time: a
// new price is taken only after the current one has left the emit state.
// The core takes the next price while a finished result still sits in the
// output register; if the receiver stalls, the following result waits in the
// core until the register frees, and in_ready stays low meanwhile.
// Reset clears pointers, fill count, momentum and config to defaults; the ring
// contents are not cleared (an entry is only read after it was written).
`default_nettype none
`include "moving_average_crossover_signal_core_assert.svh"

module moving_average_crossover_signal_core
    import macs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // price input
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [31:0]         price,
    // result output
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [1:0]          signal_kind,
    output logic      [31:0]         signal_size,
    output logic signed [31:0]       momentum,
    output logic                     window_full,
    // register writes
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [IDX_W-1:0]    cfg_index,
    input  wire logic [DATA_W-1:0]   cfg_data
);

    // Config registers
    logic [PERIOD_W-1:0] short_period_reg;
    logic [PERIOD_W-1:0] long_period_reg;
    logic [THR_W-1:0]    threshold_reg;
    logic [SIZE_W-1:0]   size_reg;

    // Control state
    state_t           state_reg, state_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] lp_reg, lp_next;
    logic [PERIOD_W-1:0] sp_reg, sp_next;
    logic             short_en_reg, short_en_next;
    logic             full_reg, full_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic [CNT_W-1:0] acc_cnt_reg, acc_cnt_next;
    logic             rvalid_reg, rvalid_next;
    logic [SUM_W-1:0] short_sum_reg, short_sum_next;
    logic [SUM_W-1:0] long_sum_reg, long_sum_next;
    logic [MOM_W-1:0] momentum_reg, momentum_next;

    // Datapath payload
    logic [PROD_W-1:0] a_reg, a_next;
    logic [PROD_W-1:0] b_reg, b_next;
    logic [PROD_W-1:0] diff_reg, diff_next;
    logic              neg_reg, neg_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    kind_t             signal_kind_reg, signal_kind_next;
    logic [SIZE_W-1:0] signal_size_reg, signal_size_next;
    logic [MOM_W-1:0]  momentum_out_reg, momentum_out_next;
    logic              window_full_reg, window_full_next;

    // Ring and divider hookup
    logic                  ring_we;
    logic [PRICE_BITS-1:0] ring_wdata;
    logic                  ring_re;
    logic [PTR_W-1:0]      ring_raddr;
    logic [PRICE_BITS-1:0] ring_rdata;
    logic                  div_start;
    div_stat_t             div_stat;
    logic [Q_W-1:0]        div_q;

    // Scratch
    logic [CNT_W-1:0]     lp_eff;
    logic [PERIOD_W-1:0]  sp_eff;
    logic [PTR_W-1:0]     wp_inc;
    logic                 in_acc;
    logic                 out_free;
    logic signed [MOM_W:0] mv_w;
    logic signed [MOM_W:0] thr_w;
    logic [MOM_W-1:0]     q_ext;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_period_reg <= SHORT_PERIOD_RST;
            long_period_reg  <= LONG_PERIOD_RST;
            threshold_reg    <= THRESHOLD_RST;
            size_reg         <= SIZE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SHORT_PERIOD: short_period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_LONG_PERIOD:  long_period_reg  <= cfg_data[PERIOD_W-1:0];
                CFG_THRESHOLD:    threshold_reg    <= cfg_data[THR_W-1:0];
                CFG_SIZE:         size_reg         <= cfg_data[SIZE_W-1:0];
            endcase
        end
    end

    macs_ring u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (wp_reg),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    macs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_reg),
        .divisor  (b_reg),
        .stat     (div_stat),
        .quotient (div_q)
    );

    always_comb
    begin
        lp_eff     = clamp_long(long_period_reg);
        sp_eff     = clamp_short(short_period_reg);
        wp_inc     = (wp_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
        ring_wdata = PRICE_BITS'(price);
        ring_raddr = (rd_ptr_reg == '0) ? PTR_W'(WINDOW_DEPTH - 1) : rd_ptr_reg - PTR_W'(1);
        q_ext      = {1'b0, div_q};
        mv_w       = $signed({momentum_reg[MOM_W-1], momentum_reg});
        thr_w      = $signed({{(MOM_W + 1 - THR_W){1'b0}}, threshold_reg});

        state_next     = state_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        lp_next        = lp_reg;
        sp_next        = sp_reg;
        short_en_next  = short_en_reg;
        full_next      = full_reg;
        rd_ptr_next    = rd_ptr_reg;
        issue_cnt_next = issue_cnt_reg;
        acc_cnt_next   = acc_cnt_reg;
        rvalid_next    = 1'b0;
        short_sum_next = short_sum_reg;
        long_sum_next  = long_sum_reg;
        momentum_next  = momentum_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        diff_next      = diff_reg;
        neg_next       = neg_reg;
        ring_we        = 1'b0;
        ring_re        = 1'b0;
        div_start      = 1'b0;

        out_valid_next    = out_valid_reg && !out_ready;
        signal_kind_next  = signal_kind_reg;
        signal_size_next  = signal_size_reg;
        momentum_out_next = momentum_out_reg;
        window_full_next  = window_full_reg;

        // Accumulate the word read in the previous cycle
        if (rvalid_reg)
        begin
            long_sum_next = long_sum_reg + SUM_W'(ring_rdata);
            if (short_en_reg && (CMP_W'(acc_cnt_reg) < CMP_W'(sp_reg)))
            begin
                short_sum_next = short_sum_reg + SUM_W'(ring_rdata);
            end
            acc_cnt_next = acc_cnt_reg + CNT_W'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    // store the price, advance pointer and fill count
                    ring_we       = 1'b1;
                    wp_next       = wp_inc;
                    fill_next     = (fill_reg == CNT_W'(WINDOW_DEPTH)) ?
                                    fill_reg : fill_reg + CNT_W'(1);
                    lp_next       = lp_eff;
                    sp_next       = sp_eff;
                    short_en_next = CMP_W'(sp_eff) <= CMP_W'(lp_eff);
                    full_next     = fill_next >= lp_eff;
                    rd_ptr_next   = wp_inc;
                    issue_cnt_next = '0;
                    acc_cnt_next   = '0;
                    short_sum_next = '0;
                    long_sum_next  = '0;
                    state_next     = full_next ? ST_READ : ST_EMIT;
                end
            end

            ST_READ:
            begin
                // walk back from the newest price, one read a cycle
                if (issue_cnt_reg != lp_reg)
                begin
                    ring_re        = 1'b1;
                    rvalid_next    = 1'b1;
                    rd_ptr_next    = ring_raddr;
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                else if (rvalid_reg)
                begin
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                if (long_sum_reg == '0)
                begin
                    // no long average: keep the previous momentum
                    state_next = ST_EMIT;
                end
                else
                begin
                    a_next     = PROD_W'(short_sum_reg) * PROD_W'(lp_reg);
                    b_next     = PROD_W'(long_sum_reg) * PROD_W'(sp_reg);
                    state_next = ST_SUB;
                end
            end

            ST_SUB:
            begin
                neg_next   = a_reg < b_reg;
                diff_next  = (a_reg < b_reg) ? b_reg - a_reg : a_reg - b_reg;
                state_next = ST_START;
            end

            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    momentum_next = neg_reg ? MOM_W'(0) - q_ext : q_ext;
                    state_next    = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                // hold here until the output register can take the word
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    momentum_out_next = momentum_reg;
                    window_full_next  = full_reg;
                    signal_kind_next  = KIND_HOLD;
                    signal_size_next  = '0;
                    if (full_reg && (mv_w > thr_w))
                    begin
                        signal_kind_next = KIND_BUY;
                        signal_size_next = size_reg;
                    end
                    else if (full_reg && (mv_w < -thr_w))
                    begin
                        signal_kind_next = KIND_SELL;
                        signal_size_next = size_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            lp_reg        <= '0;
            sp_reg        <= '0;
            short_en_reg  <= 1'b0;
            full_reg      <= 1'b0;
            rd_ptr_reg    <= '0;
            issue_cnt_reg <= '0;
            acc_cnt_reg   <= '0;
            rvalid_reg    <= 1'b0;
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
            momentum_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            lp_reg        <= lp_next;
            sp_reg        <= sp_next;
            short_en_reg  <= short_en_next;
            full_reg      <= full_next;
            rd_ptr_reg    <= rd_ptr_next;
            issue_cnt_reg <= issue_cnt_next;
            acc_cnt_reg   <= acc_cnt_next;
            rvalid_reg    <= rvalid_next;
            short_sum_reg <= short_sum_next;
            long_sum_reg  <= long_sum_next;
            momentum_reg  <= momentum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg            <= a_next;
        b_reg            <= b_next;
        diff_reg         <= diff_next;
        neg_reg          <= neg_next;
        signal_kind_reg  <= signal_kind_next;
        signal_size_reg  <= signal_size_next;
        momentum_out_reg <= momentum_out_next;
        window_full_reg  <= window_full_next;
    end

    assign out_valid   = out_valid_reg;
    assign signal_kind = signal_kind_reg;
    assign signal_size = signal_size_reg;
    assign momentum    = $signed(momentum_out_reg);
    assign window_full = window_full_reg;

    `MACS_ASSERT(a_no_ring_overlap, clk, rst_n, !(ring_we && ring_re),
                 "ring written and read in one cycle")
    `MACS_ASSERT(a_div_engaged, clk, rst_n,
                 (state_reg == ST_DIV) |-> (div_stat.busy || div_stat.done),
                 "waiting on an idle divider")
    `MACS_ASSERT_NEXT(a_start_enters_div, clk, rst_n, div_start, state_reg == ST_DIV,
                      "divider started outside the divide step")
    `MACS_ASSERT(a_hold_until_full, clk, rst_n,
                 (out_valid_reg && !window_full_reg) |->
                 ((signal_kind_reg == KIND_HOLD) && (signal_size_reg == '0)),
                 "trade signal before window filled")

endmodule

`default_nettype wire
